FILE: hw/rtl/sat_pkg.sv
// Shared types and constants for the summed-area table block.
`timescale 1ns / 1ps

package sat_pkg;

    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int ELEM_W   = 16;
    localparam int ROWSUM_W = ELEM_W + COL_W;
    localparam int TABLE_W  = ROWSUM_W + ROW_W;
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [CFG_W-1:0] ROWS_MAX = 7'd64;
    localparam logic [CFG_W-1:0] COLS_MAX = 7'd64;
    localparam logic [CFG_W-1:0] CFG_MIN  = 7'd1;

    localparam logic [ROW_W-1:0] ROW_ONE = 6'd1;
    localparam logic [COL_W-1:0] COL_ONE = 6'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE  = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_Q_RD,
        ST_Q_OUT
    } state_t;

    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [ADDR_W-1:0]   addr;
        logic [TABLE_W-1:0]  wdata;
    } ram_req_t;

endpackage

FILE: hw/rtl/summed_area_table_rect_sum.sv
// A load reads the entry above, then writes the new entry.
// A valid query makes four reads of the single-port table, then outputs.
// A rejected query makes no table reads and goes straight to the output state.
// Throughput is one item at a time, set by the single table port.
// aresetn is synchronous, active low: clears position, sums, loaded flag, m_tvalid, sizes (64x64).
// Table contents are not cleared; every entry used was written in the current pass.
`timescale 1ns / 1ps

module summed_area_table_rect_sum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_index,
    input  logic [sat_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // element[15:0], top_row[21:16], left_col[27:22], bottom_row[33:28], right_col[39:34]
    input  logic [sat_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rect_sum[27:0], status[29:28], zero fill [31:30]
    output logic [sat_pkg::M_TDATA_W-1:0]     m_tdata
);

    sat_pkg::state_t state_reg, state_next;

    logic [sat_pkg::CFG_W-1:0]    rows_reg, cols_reg;
    logic [sat_pkg::ROW_W-1:0]    load_row_reg;
    logic [sat_pkg::COL_W-1:0]    load_col_reg;
    logic                         complete_reg;
    logic [sat_pkg::ROWSUM_W-1:0] rs_reg;

    logic [sat_pkg::ROW_W-1:0]    top_reg, bottom_reg;
    logic [sat_pkg::COL_W-1:0]    left_reg, right_reg;
    logic [1:0]                   idx_reg;
    logic [sat_pkg::TABLE_W-1:0]  acc_reg;
    logic                         rd_neg_reg, rd_zero_reg;
    logic [sat_pkg::STATUS_W-1:0] qstatus_reg;

    logic                         m_valid_reg;
    logic [sat_pkg::TABLE_W-1:0]  m_sum_reg;
    logic [sat_pkg::STATUS_W-1:0] m_status_reg;

    sat_pkg::ram_req_t            ram_req;
    logic [sat_pkg::TABLE_W-1:0]  rd_data;

    logic [sat_pkg::ELEM_W-1:0]   in_elem;
    logic [sat_pkg::ROW_W-1:0]    in_top, in_bottom;
    logic [sat_pkg::COL_W-1:0]    in_left, in_right;

    logic                         s_accept, out_free;
    logic [sat_pkg::ROW_W-1:0]    row_eff;
    logic [sat_pkg::COL_W-1:0]    col_eff;
    logic [sat_pkg::ROWSUM_W-1:0] elem_ext, rs_new;
    logic                         q_bad;
    logic [sat_pkg::STATUS_W-1:0] q_status;
    logic [sat_pkg::TABLE_W-1:0]  term, term_s, entry, acc_sum;
    logic [sat_pkg::ROW_W-1:0]    c_row;
    logic [sat_pkg::COL_W-1:0]    c_col;
    logic                         c_neg, c_zero;
    logic [sat_pkg::CFG_W-1:0]    cfg_rows, cfg_cols;

    assign in_elem   = s_tdata[15:0];
    assign in_top    = s_tdata[21:16];
    assign in_left   = s_tdata[27:22];
    assign in_bottom = s_tdata[33:28];
    assign in_right  = s_tdata[39:34];

    sat_ram u_sat_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == sat_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // A load after completion restarts at the origin.
    assign row_eff = complete_reg ? '0 : load_row_reg;
    assign col_eff = complete_reg ? '0 : load_col_reg;

    assign elem_ext = {{(sat_pkg::ROWSUM_W - sat_pkg::ELEM_W){in_elem[sat_pkg::ELEM_W-1]}},
                       in_elem};
    assign rs_new   = (col_eff == '0) ? elem_ext : rs_reg + elem_ext;

    assign q_bad = (in_top > in_bottom) || (in_left > in_right)
                || ({1'b0, in_bottom} >= rows_reg) || ({1'b0, in_right} >= cols_reg);
    assign q_status = !complete_reg ? sat_pkg::STATUS_NOT_LOADED :
                      q_bad         ? sat_pkg::STATUS_BAD_RANGE  : sat_pkg::STATUS_OK;

    // Pending read term; row -1 or column -1 reads as zero.
    assign term    = rd_zero_reg ? '0 : rd_data;
    assign term_s  = rd_neg_reg ? (~term + 1'b1) : term;
    assign acc_sum = acc_reg + term_s;
    assign entry   = {{(sat_pkg::TABLE_W - sat_pkg::ROWSUM_W){rs_reg[sat_pkg::ROWSUM_W-1]}},
                      rs_reg} + term;

    // Corners 1..3: (t-1, r) minus, (b, l-1) minus, (t-1, l-1) plus.
    assign c_row  = idx_reg[0] ? top_reg - sat_pkg::ROW_ONE : bottom_reg;
    assign c_col  = idx_reg[1] ? left_reg - sat_pkg::COL_ONE : right_reg;
    assign c_neg  = idx_reg[0] ^ idx_reg[1];
    assign c_zero = (idx_reg[0] && (top_reg == '0)) || (idx_reg[1] && (left_reg == '0));

    assign cfg_rows = (cfg_wdata < sat_pkg::CFG_MIN)  ? sat_pkg::CFG_MIN  :
                      (cfg_wdata > sat_pkg::ROWS_MAX) ? sat_pkg::ROWS_MAX : cfg_wdata;
    assign cfg_cols = (cfg_wdata < sat_pkg::CFG_MIN)  ? sat_pkg::CFG_MIN  :
                      (cfg_wdata > sat_pkg::COLS_MAX) ? sat_pkg::COLS_MAX : cfg_wdata;

    always_comb begin
        state_next    = state_reg;
        ram_req.wr_en = 1'b0;
        ram_req.rd_en = 1'b0;
        ram_req.addr  = {c_row, c_col};
        ram_req.wdata = entry;
        unique case (state_reg)
            sat_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == sat_pkg::CMD_LOAD) begin
                        ram_req.rd_en = 1'b1;
                        ram_req.addr  = {row_eff - sat_pkg::ROW_ONE, col_eff};
                        state_next    = sat_pkg::ST_LD_WR;
                    end else if (q_status == sat_pkg::STATUS_OK) begin
                        ram_req.rd_en = 1'b1;
                        ram_req.addr  = {in_bottom, in_right};
                        state_next    = sat_pkg::ST_Q_RD;
                    end else begin
                        state_next = sat_pkg::ST_Q_OUT;
                    end
                end
            end
            sat_pkg::ST_LD_WR: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = {load_row_reg, load_col_reg};
                state_next    = sat_pkg::ST_IDLE;
            end
            sat_pkg::ST_Q_RD: begin
                ram_req.rd_en = 1'b1;
                if (idx_reg == 2'd3) begin
                    state_next = sat_pkg::ST_Q_OUT;
                end
            end
            sat_pkg::ST_Q_OUT: begin
                if (out_free) begin
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sat_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sat_pkg::ST_IDLE;
            rows_reg     <= sat_pkg::ROWS_MAX;
            cols_reg     <= sat_pkg::COLS_MAX;
            load_row_reg <= '0;
            load_col_reg <= '0;
            complete_reg <= 1'b0;
            rs_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    sat_pkg::REG_ROWS: rows_reg <= cfg_rows;
                    sat_pkg::REG_COLS: cols_reg <= cfg_cols;
                    default: rows_reg <= rows_reg;
                endcase
                load_row_reg <= '0;
                load_col_reg <= '0;
                complete_reg <= 1'b0;
                rs_reg       <= '0;
            end else if (s_accept && (s_tuser == sat_pkg::CMD_LOAD)) begin
                load_row_reg <= row_eff;
                load_col_reg <= col_eff;
                complete_reg <= 1'b0;
                rs_reg       <= rs_new;
            end else if (state_reg == sat_pkg::ST_LD_WR) begin
                // advance to the next element in row-major order
                if ({1'b0, load_col_reg} + 1'b1 >= cols_reg) begin
                    load_col_reg <= '0;
                    if ({1'b0, load_row_reg} + 1'b1 >= rows_reg) begin
                        load_row_reg <= '0;
                        complete_reg <= 1'b1;
                    end else begin
                        load_row_reg <= load_row_reg + sat_pkg::ROW_ONE;
                    end
                end else begin
                    load_col_reg <= load_col_reg + sat_pkg::COL_ONE;
                end
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if ((state_reg == sat_pkg::ST_Q_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            top_reg     <= in_top;
            left_reg    <= in_left;
            bottom_reg  <= in_bottom;
            right_reg   <= in_right;
            qstatus_reg <= q_status;
            acc_reg     <= '0;
            idx_reg     <= 2'd1;
            rd_neg_reg  <= 1'b0;
            rd_zero_reg <= (s_tuser == sat_pkg::CMD_LOAD) && (row_eff == '0);
        end else if (state_reg == sat_pkg::ST_Q_RD) begin
            idx_reg     <= idx_reg + 2'd1;
            acc_reg     <= acc_sum;
            rd_neg_reg  <= c_neg;
            rd_zero_reg <= c_zero;
        end
        if ((state_reg == sat_pkg::ST_Q_OUT) && out_free) begin
            m_sum_reg    <= (qstatus_reg == sat_pkg::STATUS_OK) ? acc_sum : '0;
            m_status_reg <= qstatus_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(sat_pkg::M_TDATA_W - sat_pkg::TABLE_W - sat_pkg::STATUS_W){1'b0}},
                       m_status_reg, m_sum_reg};

endmodule

FILE: hw/rtl/sat_ram.sv
// Single-port prefix table memory with registered read data.
`timescale 1ns / 1ps

module sat_ram (
    input  logic                          aclk,
    input  sat_pkg::ram_req_t             req,
    output logic [sat_pkg::TABLE_W-1:0]   rd_data
);

    logic [sat_pkg::TABLE_W-1:0] table_mem [sat_pkg::DEPTH];
    logic [sat_pkg::TABLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            table_mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_data_reg <= table_mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/sat_checker.sv
// Port-level assertions for the summed-area table block, bound to the top level.
`timescale 1ns / 1ps

module sat_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_index,
    input  logic [sat_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [sat_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [sat_pkg::M_TDATA_W-1:0]     m_tdata
);

    // Reset drops any pending result.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result transfer holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Error results carry a zero sum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[29:28] != sat_pkg::STATUS_OK) |-> (m_tdata[27:0] == '0))
        else $error("nonzero sum with error status");

    // Status code is defined and fill bits stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:28] != 2'd3) && (m_tdata[31:30] == 2'd0))
        else $error("undefined status or fill bits set");

    // A load holds off the next item while its entry is written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == sat_pkg::CMD_LOAD) |=> !s_tready)
        else $error("input ready during load write");

endmodule

bind summed_area_table_rect_sum sat_checker u_sat_checker (.*);
